FILE: rtl/core/sstb_pkg.sv
package sstb_pkg;

   // signal states for traction cut and emergency brake
   typedef enum logic [1:0] {
      SIG_FREE   = 2'd0,
      SIG_OPEN   = 2'd1,
      SIG_BYPASS = 2'd2
   } sig_type;

   // buzzer states
   typedef enum logic [1:0] {
      BUZ_OFF   = 2'd0,
      BUZ_CONT  = 2'd1,
      BUZ_INTER = 2'd2
   } buzzer_type;

   // operating modes, codes six and seven are unused
   typedef enum logic [2:0] {
      MODE_NORMAL   = 3'd0,
      MODE_LIMITED  = 3'd1,
      MODE_TOTAL    = 3'd2,
      MODE_STOP     = 3'd3,
      MODE_DRIFTING = 3'd4,
      MODE_INTERMIT = 3'd5
   } mode_type;

   // chop cycle phases
   typedef enum logic [1:0] {
      PH_READY = 2'd0,
      PH_ACCEL = 2'd1,
      PH_DECEL = 2'd2,
      PH_BRAKE = 2'd3
   } chop_phase_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_DECEL_LIMIT  = 3'd0,
      CSR_ACCEL_LIMIT  = 3'd1,
      CSR_BRAKE_LIMIT  = 3'd2,
      CSR_BRAKE_HOLD   = 3'd3,
      CSR_CHOP_ACCEL   = 3'd4,
      CSR_CHOP_DECEL   = 3'd5,
      CSR_CHOP_CYCLES  = 3'd6,
      CSR_CHOP_BRAKE   = 3'd7
   } csr_idx_type;

   localparam int unsigned MS_PER_S            = 1000;
   localparam logic [7:0]  STOP_SPEED_KMH      = 8'd1;
   localparam int unsigned START_BRAKE_SECONDS = 10;
   localparam logic [31:0] START_BRAKE_MS      = 32'(START_BRAKE_SECONDS * MS_PER_S);
   localparam logic [7:0]  CHOP_CYCLES_RESET   = 8'd1;

   // true when more than secs seconds have passed since the given time
   function automatic logic elapsed_over(input logic [31:0] now,
                                         input logic [31:0] since,
                                         input logic [7:0]  secs);
      logic [31:0] diff;
      logic [31:0] limit;
      diff  = now - since;
      limit = 32'(secs) * 32'(MS_PER_S);
      return diff > limit;
   endfunction

endpackage

FILE: rtl/core/speed_supervision_traction_brake_ctrl.sv
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | now_ms, mode, speed, presence, limited start
// rsp     | out       | rsp_valid / rsp_ready | traction, brake, buzzer, change flags
// csr     | in        | csr_valid / csr_ready | register index, 8-bit data
//
// Each item passes through the input register and then the result register;
// one item per cycle is sustained while rsp does not stall.
// The state update (signals, brake timer, chop phase) happens in one pass of
// compare logic between those registers, so items follow each other with no gap.
// Synchronous active-high reset clears the pipeline and loads register defaults.
// A stall on rsp holds the result register and, once the input register is full,
// drops req_ready in the same cycle. csr_ready is always high.
module speed_supervision_traction_brake_ctrl (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_speed_kmh,
   input  logic        req_speed_present,
   input  logic [31:0] req_limited_start_ms,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_traction_state,
   output logic [1:0]  rsp_brake_state,
   output logic [1:0]  rsp_buzzer_mode,
   output logic        rsp_traction_changed,
   output logic        rsp_brake_changed,
   // configuration port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  sstb_pkg::csr_idx_type csr_index,
   input  logic [7:0]  csr_data
);
   import sstb_pkg::*;

   // configuration registers
   logic [7:0] decel_limit_ff, accel_limit_ff, brake_limit_ff, brake_hold_ff;
   logic [7:0] chop_accel_ff, chop_decel_ff, chop_cycles_ff, chop_brake_ff;

   // input register
   logic        in_valid_ff;
   logic [31:0] in_now_ff;
   mode_type    in_mode_ff;
   logic [7:0]  in_speed_ff;
   logic        in_present_ff;
   logic [31:0] in_lim_start_ff;

   // block state
   sig_type        traction_ff, traction_in;
   sig_type        brake_ff, brake_in;
   buzzer_type     buzzer_ff, buzzer_in;
   logic [31:0]    brake_open_ff, brake_open_in;
   chop_phase_type phase_ff, phase_in;
   logic [31:0]    phase_start_ff, phase_start_in;
   logic [7:0]     cycle_cnt_ff, cycle_cnt_in;

   // result register
   logic       out_valid_ff;
   sig_type    out_traction_ff;
   sig_type    out_brake_ff;
   buzzer_type out_buzzer_ff;
   logic       out_t_chg_ff;
   logic       out_b_chg_ff;

   logic       advance;
   logic       run_chop;
   sig_type    chop_active;
   logic [7:0] cycle_inc;

   // pipeline flow control
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         decel_limit_ff <= '0;
         accel_limit_ff <= '0;
         brake_limit_ff <= '0;
         brake_hold_ff  <= '0;
         chop_accel_ff  <= '0;
         chop_decel_ff  <= '0;
         chop_cycles_ff <= CHOP_CYCLES_RESET;
         chop_brake_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DECEL_LIMIT: decel_limit_ff <= csr_data;
            CSR_ACCEL_LIMIT: accel_limit_ff <= csr_data;
            CSR_BRAKE_LIMIT: brake_limit_ff <= csr_data;
            CSR_BRAKE_HOLD:  brake_hold_ff  <= csr_data;
            CSR_CHOP_ACCEL:  chop_accel_ff  <= csr_data;
            CSR_CHOP_DECEL:  chop_decel_ff  <= csr_data;
            CSR_CHOP_CYCLES: chop_cycles_ff <= csr_data;
            CSR_CHOP_BRAKE:  chop_brake_ff  <= csr_data;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_now_ff       <= req_now_ms;
         in_mode_ff      <= mode_type'(req_mode);
         in_speed_ff     <= req_speed_kmh;
         in_present_ff   <= req_speed_present;
         in_lim_start_ff <= req_limited_start_ms;
      end
   end

   // next state for one evaluation
   assign cycle_inc = cycle_cnt_ff + 8'd1;

   always_comb begin
      traction_in    = traction_ff;
      brake_in       = brake_ff;
      buzzer_in      = buzzer_ff;
      brake_open_in  = brake_open_ff;
      phase_in       = phase_ff;
      phase_start_in = phase_start_ff;
      cycle_cnt_in   = cycle_cnt_ff;
      run_chop       = 1'b0;
      chop_active    = SIG_FREE;

      // mode decode
      unique case (in_mode_ff)
         MODE_NORMAL: begin
            traction_in = SIG_FREE;
            brake_in    = SIG_FREE;
         end
         MODE_LIMITED: begin
            if (in_present_ff) begin
               // overspeed cut with hysteresis
               if (in_speed_ff > decel_limit_ff) begin
                  traction_in = SIG_OPEN;
                  buzzer_in   = BUZ_CONT;
               end else if (traction_ff == SIG_OPEN && brake_ff == SIG_FREE &&
                            in_speed_ff < accel_limit_ff) begin
                  traction_in = SIG_FREE;
                  buzzer_in   = BUZ_INTER;
               end
               // brake open, held, released near standstill
               if (brake_ff == SIG_FREE && in_speed_ff > brake_limit_ff) begin
                  brake_in      = SIG_OPEN;
                  brake_open_in = in_now_ff;
               end else if (elapsed_over(in_now_ff, brake_open_ff, brake_hold_ff) &&
                            in_speed_ff < STOP_SPEED_KMH) begin
                  brake_in = SIG_FREE;
               end
            end else if ((in_now_ff - in_lim_start_ff) < START_BRAKE_MS) begin
               traction_in = SIG_OPEN;
               brake_in    = SIG_OPEN;
            end else begin
               run_chop    = 1'b1;
               chop_active = SIG_FREE;
            end
         end
         MODE_TOTAL: begin
            traction_in = SIG_BYPASS;
            brake_in    = SIG_BYPASS;
         end
         MODE_STOP: begin
            traction_in = SIG_OPEN;
            brake_in    = SIG_OPEN;
         end
         MODE_DRIFTING: begin
            traction_in = SIG_OPEN;
            brake_in    = SIG_BYPASS;
         end
         MODE_INTERMIT: begin
            run_chop    = 1'b1;
            chop_active = SIG_BYPASS;
         end
         default: begin
         end
      endcase

      // chop cycle sequencer
      if (run_chop) begin
         unique case (phase_ff)
            PH_READY: begin
               traction_in    = chop_active;
               brake_in       = chop_active;
               phase_start_in = in_now_ff;
               phase_in       = PH_ACCEL;
            end
            PH_ACCEL: begin
               if (elapsed_over(in_now_ff, phase_start_ff, chop_accel_ff)) begin
                  traction_in    = SIG_OPEN;
                  brake_in       = chop_active;
                  phase_start_in = in_now_ff;
                  phase_in       = PH_DECEL;
               end
            end
            PH_DECEL: begin
               if (elapsed_over(in_now_ff, phase_start_ff, chop_decel_ff)) begin
                  if (cycle_inc == chop_cycles_ff) begin
                     cycle_cnt_in   = '0;
                     traction_in    = SIG_OPEN;
                     brake_in       = SIG_OPEN;
                     phase_start_in = in_now_ff;
                     phase_in       = PH_BRAKE;
                  end else begin
                     cycle_cnt_in = cycle_inc;
                     phase_in     = PH_READY;
                  end
               end
            end
            PH_BRAKE: begin
               if (elapsed_over(in_now_ff, phase_start_ff, chop_brake_ff)) begin
                  phase_in = PH_READY;
               end
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         traction_ff    <= SIG_FREE;
         brake_ff       <= SIG_FREE;
         buzzer_ff      <= BUZ_OFF;
         brake_open_ff  <= '0;
         phase_ff       <= PH_READY;
         phase_start_ff <= '0;
         cycle_cnt_ff   <= '0;
      end else if (advance) begin
         traction_ff    <= traction_in;
         brake_ff       <= brake_in;
         buzzer_ff      <= buzzer_in;
         brake_open_ff  <= brake_open_in;
         phase_ff       <= phase_in;
         phase_start_ff <= phase_start_in;
         cycle_cnt_ff   <= cycle_cnt_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         out_traction_ff <= traction_in;
         out_brake_ff    <= brake_in;
         out_buzzer_ff   <= buzzer_in;
         out_t_chg_ff    <= traction_in != traction_ff;
         out_b_chg_ff    <= brake_in != brake_ff;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_traction_state   = out_traction_ff;
   assign rsp_brake_state      = out_brake_ff;
   assign rsp_buzzer_mode      = out_buzzer_ff;
   assign rsp_traction_changed = out_t_chg_ff;
   assign rsp_brake_changed    = out_b_chg_ff;

endmodule

FILE: rtl/core/sstb_checker.sv
module sstb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_traction_state,
   input logic [1:0]  rsp_brake_state,
   input logic [1:0]  rsp_buzzer_mode
);
   import sstb_pkg::*;

   // items accepted but not yet delivered
   logic [2:0] occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_ff + 3'((req_valid && req_ready) ? 1 : 0)
                          - 3'((rsp_valid && rsp_ready) ? 1 : 0);
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_traction_state) &&
         $stable(rsp_brake_state) && $stable(rsp_buzzer_mode))
      else $error("stalled result changed");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // result codes never hit the unused encoding
   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_traction_state != 2'd3 && rsp_brake_state != 2'd3 &&
         rsp_buzzer_mode != 2'd3)
      else $error("unused code on result");

   // at most two items in flight, and a result only for an accepted item
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= 3'd2 && (occ_ff != 3'd0 || !rsp_valid))
      else $error("item count out of range");

   // full pipeline under stall blocks new items
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      occ_ff == 3'd2 && !rsp_ready |-> !req_ready)
      else $error("item accepted into full pipeline");

endmodule

bind speed_supervision_traction_brake_ctrl sstb_checker u_sstb_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_traction_state (rsp_traction_state),
   .rsp_brake_state    (rsp_brake_state),
   .rsp_buzzer_mode    (rsp_buzzer_mode)
);
